@@ src/fcal_pkg.sv @@
`default_nettype none
package fcal_pkg;

  localparam int ENTRIES = 2048;
  localparam int IDX_W   = $clog2(ENTRIES);
  localparam int CNT_W   = $clog2(ENTRIES + 1);
  localparam int VAL_W   = 16;
  localparam int DBC_W   = 12;
  localparam int FREE_W  = 12;

  localparam logic [VAL_W-1:0] CHAIN_END  = 16'hFFFF;
  localparam logic [VAL_W-1:0] NONE_INDEX = 16'hFFFF;

  localparam logic [2:0] OP_LOAD  = 3'd0;
  localparam logic [2:0] OP_ALLOC = 3'd1;
  localparam logic [2:0] OP_EXT   = 3'd2;
  localparam logic [2:0] OP_FREE  = 3'd3;
  localparam logic [2:0] OP_NEXT  = 3'd4;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_RECOUNT,
    S_IDLE,
    S_RD,
    S_RD2,
    S_SCAN,
    S_WB_END,
    S_LINK,
    S_FC_RD,
    S_FC_CHK,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    logic [VAL_W-1:0] wdata;
    logic [IDX_W-1:0] raddr;
  } mem_req_t;

  typedef struct packed {
    logic [VAL_W-1:0]  result_index;
    status_t           status;
    logic [FREE_W-1:0] free_entries;
  } res_t;

  function automatic logic [CNT_W-1:0] used_of(input logic [DBC_W-1:0] dbc);
    logic [CNT_W-1:0] r;
    if (CNT_W'(dbc) > CNT_W'(ENTRIES)) r = CNT_W'(ENTRIES);
    else r = CNT_W'(dbc);
    return r;
  endfunction

endpackage
`default_nettype wire

@@ src/fcal_ram.sv @@
`default_nettype none
module fcal_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2048
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

@@ src/fcal_ctrl.sv @@
`default_nettype none
module fcal_ctrl import fcal_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [2:0]        in_operation,
  input  wire logic [IDX_W-1:0]  in_entry_index,
  input  wire logic [VAL_W-1:0]  in_entry_value,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [DBC_W-1:0]  cfg_data,
  input  wire logic              out_slot_free,
  output logic                   done,
  output res_t                   result,
  output mem_req_t               mem_req,
  input  wire logic [VAL_W-1:0]  mem_rdata
);

  state_t            state_r, state_nxt;
  logic [2:0]        op_r, op_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic [VAL_W-1:0]  val_r, val_nxt;
  logic [CNT_W-1:0]  scan_r, scan_nxt;
  logic              pv_r, pv_nxt;
  logic [IDX_W-1:0]  pa_r, pa_nxt;
  logic [CNT_W-1:0]  skip_r, skip_nxt;
  logic [IDX_W-1:0]  f_r, f_nxt;
  logic              tail_zero_r, tail_zero_nxt;
  logic [IDX_W-1:0]  cur_r, cur_nxt;
  logic [CNT_W-1:0]  clr_r, clr_nxt;
  logic [FREE_W-1:0] free_r, free_nxt;
  logic [DBC_W-1:0]  dbc_r, dbc_nxt;
  logic [VAL_W-1:0]  res_r, res_nxt;
  status_t           st_r, st_nxt;

  logic [CNT_W-1:0]  n;
  logic              cfg_acc, in_acc, issue;

  assign n         = used_of(dbc_r);
  assign cfg_ready = (state_r == S_IDLE) || (state_r == S_CLEAR);
  assign in_ready  = (state_r == S_IDLE) && !cfg_valid;
  assign cfg_acc   = cfg_valid && cfg_ready;
  assign in_acc    = in_valid && in_ready;
  assign issue     = scan_r < n;

  assign result.result_index = res_r;
  assign result.status       = st_r;
  assign result.free_entries = free_r;

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    idx_nxt       = idx_r;
    val_nxt       = val_r;
    scan_nxt      = scan_r;
    pv_nxt        = pv_r;
    pa_nxt        = pa_r;
    skip_nxt      = skip_r;
    f_nxt         = f_r;
    tail_zero_nxt = tail_zero_r;
    cur_nxt       = cur_r;
    clr_nxt       = clr_r;
    free_nxt      = free_r;
    dbc_nxt       = cfg_acc ? cfg_data : dbc_r;
    res_nxt       = res_r;
    st_nxt        = st_r;
    done          = 1'b0;
    mem_req.we    = 1'b0;
    mem_req.waddr = idx_r;
    mem_req.wdata = '0;
    mem_req.raddr = scan_r[IDX_W-1:0];

    case (state_r)
      S_CLEAR: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = clr_r[IDX_W-1:0];
        clr_nxt       = clr_r + 1'b1;
        if (clr_r == CNT_W'(ENTRIES - 1)) begin
          free_nxt  = FREE_W'(used_of(dbc_nxt));
          state_nxt = S_IDLE;
        end
      end
      S_RECOUNT: begin
        pv_nxt   = issue;
        pa_nxt   = scan_r[IDX_W-1:0];
        scan_nxt = scan_r + CNT_W'(issue);
        if (pv_r && mem_rdata == '0) begin
          free_nxt = free_r + 1'b1;
        end else if (!pv_r && !issue) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (cfg_acc) begin
          scan_nxt  = '0;
          pv_nxt    = 1'b0;
          free_nxt  = '0;
          state_nxt = S_RECOUNT;
        end else if (in_acc) begin
          op_nxt   = in_operation;
          idx_nxt  = in_entry_index;
          val_nxt  = in_entry_value;
          cur_nxt  = in_entry_index;
          res_nxt  = NONE_INDEX;
          st_nxt   = ST_OK;
          scan_nxt = '0;
          pv_nxt   = 1'b0;
          skip_nxt = n;
          if (in_operation <= OP_NEXT && in_operation != OP_ALLOC &&
              CNT_W'(in_entry_index) >= n) begin
            st_nxt    = ST_RANGE;
            state_nxt = S_FINISH;
          end else begin
            case (in_operation)
              OP_LOAD, OP_NEXT: state_nxt = S_RD;
              OP_EXT: begin
                skip_nxt  = CNT_W'(in_entry_index);
                state_nxt = S_RD;
              end
              OP_ALLOC: state_nxt = S_SCAN;
              OP_FREE:  state_nxt = S_FC_RD;
              default:  state_nxt = S_FINISH;
            endcase
          end
        end
      end
      S_RD: begin
        mem_req.raddr = idx_r;
        state_nxt     = S_RD2;
      end
      S_RD2: begin
        case (op_r)
          OP_LOAD: begin
            if (mem_rdata == '0 && val_r != '0) free_nxt = free_r - 1'b1;
            else if (mem_rdata != '0 && val_r == '0) free_nxt = free_r + 1'b1;
            mem_req.we    = 1'b1;
            mem_req.waddr = idx_r;
            mem_req.wdata = val_r;
            state_nxt     = S_FINISH;
          end
          OP_NEXT: begin
            res_nxt   = mem_rdata;
            state_nxt = S_FINISH;
          end
          default: begin
            tail_zero_nxt = (mem_rdata == '0);
            state_nxt     = S_SCAN;
          end
        endcase
      end
      S_SCAN: begin
        pv_nxt   = issue;
        pa_nxt   = scan_r[IDX_W-1:0];
        scan_nxt = scan_r + CNT_W'(issue);
        if (pv_r && mem_rdata == '0 && CNT_W'(pa_r) != skip_r) begin
          f_nxt     = pa_r;
          state_nxt = S_WB_END;
        end else if (!pv_r && !issue) begin
          st_nxt    = ST_FULL;
          state_nxt = S_FINISH;
        end
      end
      S_WB_END: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = f_r;
        mem_req.wdata = CHAIN_END;
        free_nxt      = free_r - 1'b1;
        res_nxt       = VAL_W'(f_r);
        state_nxt     = (op_r == OP_EXT) ? S_LINK : S_FINISH;
      end
      S_LINK: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = idx_r;
        mem_req.wdata = VAL_W'(f_r);
        if (tail_zero_r) free_nxt = free_r - 1'b1;
        state_nxt     = S_FINISH;
      end
      S_FC_RD: begin
        mem_req.raddr = cur_r;
        state_nxt     = S_FC_CHK;
      end
      S_FC_CHK: begin
        if (mem_rdata == '0) begin
          state_nxt = S_FINISH;
        end else begin
          mem_req.we    = 1'b1;
          mem_req.waddr = cur_r;
          mem_req.wdata = '0;
          free_nxt      = free_r + 1'b1;
          if (mem_rdata == CHAIN_END) begin
            state_nxt = S_FINISH;
          end else if (mem_rdata >= VAL_W'(n)) begin
            st_nxt    = ST_RANGE;
            state_nxt = S_FINISH;
          end else begin
            cur_nxt   = mem_rdata[IDX_W-1:0];
            state_nxt = S_FC_RD;
          end
        end
      end
      S_FINISH: begin
        if (out_slot_free) begin
          done      = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      clr_r   <= '0;
      dbc_r   <= DBC_W'(ENTRIES);
      free_r  <= '0;
      scan_r  <= '0;
      pv_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      dbc_r   <= dbc_nxt;
      free_r  <= free_nxt;
      scan_r  <= scan_nxt;
      pv_r    <= pv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r        <= op_nxt;
    idx_r       <= idx_nxt;
    val_r       <= val_nxt;
    pa_r        <= pa_nxt;
    skip_r      <= skip_nxt;
    f_r         <= f_nxt;
    tail_zero_r <= tail_zero_nxt;
    cur_r       <= cur_nxt;
    res_r       <= res_nxt;
    st_r        <= st_nxt;
  end

endmodule
`default_nettype wire

@@ src/fat_chain_allocator_core.sv @@
// Load and next read the addressed entry, then write it or return it; allocate and extend
//   scan first-fit; free_chain walks a chain; an input index out of range reports ST_RANGE.
// Throughput: one word at a time; the first-fit scan reads one table entry per cycle.
// A write of the entry count recounts free entries.
// Reset: synchronous, active low; a clearing pass then zeroes all 2048 entries,
//   during which no input word is taken.
`default_nettype none
module fat_chain_allocator_core import fcal_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [2:0]        in_operation,
  input  wire logic [IDX_W-1:0]  in_entry_index,
  input  wire logic [VAL_W-1:0]  in_entry_value,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [DBC_W-1:0]  cfg_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [VAL_W-1:0]       out_result_index,
  output logic [1:0]             out_status,
  output logic [FREE_W-1:0]      out_free_entries
);

  mem_req_t         mem_req;
  logic [VAL_W-1:0] mem_rdata;
  res_t             result;
  logic             done;
  logic             out_valid_r, out_valid_nxt;
  res_t             out_r;

  fcal_ram #(
    .WIDTH(VAL_W),
    .DEPTH(ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (mem_req.we),
    .waddr (mem_req.waddr),
    .wdata (mem_req.wdata),
    .raddr (mem_req.raddr),
    .rdata (mem_rdata)
  );

  fcal_ctrl u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_operation   (in_operation),
    .in_entry_index (in_entry_index),
    .in_entry_value (in_entry_value),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_data       (cfg_data),
    .out_slot_free  (!out_valid_r || out_ready),
    .done           (done),
    .result         (result),
    .mem_req        (mem_req),
    .mem_rdata      (mem_rdata)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (done) out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      out_r <= result;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_result_index = out_r.result_index;
  assign out_status       = out_r.status;
  assign out_free_entries = out_r.free_entries;

endmodule
`default_nettype wire
